### design/hrd_pkg.sv
// Shared types, constants and helpers for the 3x3 height range dilation block.
// Used by the channel interfaces and the top level; depends on nothing else.
package hrd_pkg;

	localparam int MAX_COLS  = 512;
	localparam int MAX_ROWS  = 512;
	localparam int HEIGHT_W  = 32;
	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 2;
	localparam int COL_W     = $clog2(MAX_COLS);
	localparam int ROW_W     = $clog2(MAX_ROWS);
	// input row runs one past the frame while the tail is flushed
	localparam int IROW_W    = $clog2(MAX_ROWS + 2);

	typedef logic [CFG_W-1:0]  dim_t;
	typedef logic [COL_W-1:0]  col_t;
	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [IROW_W-1:0] irow_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_COLS = 2'd0,
		REG_IMAGE_ROWS = 2'd1
	} cfg_reg_t;

	typedef enum logic {
		OP_DATA  = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	localparam logic signed [HEIGHT_W-1:0] EMPTY_MIN = {1'b0, {(HEIGHT_W-1){1'b1}}};
	localparam logic signed [HEIGHT_W-1:0] EMPTY_MAX = {1'b1, {(HEIGHT_W-1){1'b0}}};

	// height interval of one pixel or of a merged group of pixels
	typedef struct packed {
		logic signed [HEIGHT_W-1:0] mn;
		logic signed [HEIGHT_W-1:0] mx;
	} span_t;

	localparam span_t EMPTY_SPAN = '{mn: EMPTY_MIN, mx: EMPTY_MAX};

	// line buffer entry: pixels one and two rows above, same column
	typedef struct packed {
		span_t up1;
		span_t up2;
	} line_t;

	// merge two intervals: least minimum, greatest maximum
	function automatic span_t span_merge(span_t a, span_t b);
		span_t r;
		r.mn = (a.mn < b.mn) ? a.mn : b.mn;
		r.mx = (a.mx > b.mx) ? a.mx : b.mx;
		return r;
	endfunction

endpackage

### design/hrd_in_if.sv
// Pixel request channel: valid/ready handshake plus one height map pixel.
// Depends on hrd_pkg for the height width.
interface hrd_in_if;
	logic                                valid;
	logic                                ready;
	logic                                op;
	logic signed [hrd_pkg::HEIGHT_W-1:0] min_height;
	logic signed [hrd_pkg::HEIGHT_W-1:0] max_height;

	modport source (output valid, output op, output min_height, output max_height,
		input ready);
	modport sink (input valid, input op, input min_height, input max_height,
		output ready);
endinterface

### design/hrd_out_if.sv
// Result request channel: valid/ready handshake plus one dilated pixel.
// Depends on hrd_pkg for the height and coordinate widths.
interface hrd_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [hrd_pkg::HEIGHT_W-1:0] dilated_min;
	logic signed [hrd_pkg::HEIGHT_W-1:0] dilated_max;
	logic [hrd_pkg::COL_W-1:0]           out_col;
	logic [hrd_pkg::ROW_W-1:0]           out_row;
	logic                                last_of_frame;

	modport source (output valid, output dilated_min, output dilated_max,
		output out_col, output out_row, output last_of_frame, input ready);
	modport sink (input valid, input dilated_min, input dilated_max,
		input out_col, input out_row, input last_of_frame, output ready);
endinterface

### design/height_range_dilation_3x3_top.sv
// Top level of the 3x3 min/max height dilation filter.
// Depends on hrd_pkg, hrd_in_if and hrd_out_if.
//
// Accepts one pixel request per clock cycle while the skid entry is empty and, in
// steady state, returns one result per cycle while the sink is ready. The result for
// raster pixel p is released by input request p+cols+1, then passes through three
// pipeline stages and the output register. A column-indexed line buffer (512 entries
// of two pixels) is read when a pixel is accepted and written back when stage 1
// advances, one read and one write per cycle; that single read-modify-write per pixel
// sets the rate. After the last pixel of a frame, send cols+1 flush requests to drain
// it. A write to either frame size register restarts the frame. A two-entry output
// (register plus skid) keeps input accepted while one result waits, not while two do.
module height_range_dilation_3x3_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [hrd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hrd_pkg::CFG_W-1:0]       cfg_data,
	hrd_in_if.sink                          pix_in,
	hrd_out_if.source                       res_out
);

	typedef struct packed {
		logic          rv1;       // row above exists
		logic          rv2;       // two rows above exist
		logic          emit;      // this request releases a result
		logic          incl_cur;  // current column lies inside the right edge
		logic          left;      // column two back lies inside the left edge
		logic          last;
		hrd_pkg::col_t col;
		hrd_pkg::row_t row;
	} tag_t;

	typedef struct packed {
		hrd_pkg::span_t span;
		hrd_pkg::col_t  col;
		hrd_pkg::row_t  row;
		logic           last;
	} res_t;

	// configuration and stream position
	hrd_pkg::dim_t  cols_q, rows_q;
	hrd_pkg::dim_t  cols_eff, rows_eff;
	hrd_pkg::col_t  in_col_q, ecol_q;
	hrd_pkg::irow_t in_row_q;
	hrd_pkg::row_t  erow_q;
	logic           cfg_cols_we, cfg_rows_we;

	// stage 0
	logic           adv, acc, in_data;
	hrd_pkg::span_t item0;
	tag_t           tag0;

	// stage 1 (line buffer data arrives)
	hrd_pkg::line_t row_mem [hrd_pkg::MAX_COLS];
	hrd_pkg::line_t line_rd_s1, line_old, wr_line, wr_last_q;
	logic           v_s1, fwd_s1, wr_en;
	tag_t           tag_s1;
	hrd_pkg::span_t cur_s1;
	hrd_pkg::col_t  addr_s1;
	hrd_pkg::span_t up1_m, up2_m;

	// stage 2 (column merge, horizontal window)
	logic           v_s2;
	tag_t           tag_s2;
	hrd_pkg::span_t cur_s2, pair_s2, vcol, horiz;
	hrd_pkg::span_t win_a_q, win_b_q;

	// stage 3 (final merge)
	logic           v_s3;
	tag_t           tag_s3;
	hrd_pkg::span_t vcol_s3, horiz_s3;
	res_t           res3;

	// output register and skid
	logic           out_v_q, skid_v_q, push;
	res_t           out_q, skid_q;

	// decode register writes
	always_comb begin
		cfg_cols_we = 1'b0;
		cfg_rows_we = 1'b0;
		if (cfg_we) begin
			unique case (hrd_pkg::cfg_reg_t'(cfg_index))
				hrd_pkg::REG_IMAGE_COLS: cfg_cols_we = 1'b1;
				hrd_pkg::REG_IMAGE_ROWS: cfg_rows_we = 1'b1;
				default: ;
			endcase
		end
	end

	// clamp frame size to the supported range
	always_comb begin
		if (cols_q == '0)
			cols_eff = hrd_pkg::dim_t'(1);
		else if (int'(cols_q) > hrd_pkg::MAX_COLS)
			cols_eff = hrd_pkg::dim_t'(hrd_pkg::MAX_COLS);
		else
			cols_eff = cols_q;
		if (rows_q == '0)
			rows_eff = hrd_pkg::dim_t'(1);
		else if (int'(rows_q) > hrd_pkg::MAX_ROWS)
			rows_eff = hrd_pkg::dim_t'(hrd_pkg::MAX_ROWS);
		else
			rows_eff = rows_q;
	end

	// stage 0: classify the incoming request from the stream position
	assign adv          = !skid_v_q;
	assign pix_in.ready = adv;
	assign acc          = pix_in.valid && adv;
	assign in_data      = int'(in_row_q) < int'(rows_eff);

	always_comb begin
		if (in_data && hrd_pkg::op_t'(pix_in.op) == hrd_pkg::OP_DATA)
			item0 = '{mn: pix_in.min_height, mx: pix_in.max_height};
		else
			item0 = hrd_pkg::EMPTY_SPAN;
		tag0.rv1      = in_row_q != '0;
		tag0.rv2      = in_row_q >= hrd_pkg::irow_t'(2);
		tag0.emit     = (in_row_q >= hrd_pkg::irow_t'(2)) ||
			(in_row_q == hrd_pkg::irow_t'(1) && in_col_q != '0);
		tag0.incl_cur = in_col_q != '0;
		tag0.left     = (in_col_q >= hrd_pkg::col_t'(2)) ||
			(in_col_q == '0 && cols_eff >= hrd_pkg::dim_t'(2));
		tag0.last     = (hrd_pkg::dim_t'(ecol_q) == cols_eff - hrd_pkg::dim_t'(1)) &&
			(hrd_pkg::dim_t'(erow_q) == rows_eff - hrd_pkg::dim_t'(1));
		tag0.col      = ecol_q;
		tag0.row      = erow_q;
	end

	// hold configuration and advance the input and result positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q   <= hrd_pkg::dim_t'(256);
			rows_q   <= hrd_pkg::dim_t'(256);
			in_col_q <= '0;
			in_row_q <= '0;
			ecol_q   <= '0;
			erow_q   <= '0;
		end else if (cfg_cols_we || cfg_rows_we) begin
			if (cfg_cols_we)
				cols_q <= cfg_data;
			if (cfg_rows_we)
				rows_q <= cfg_data;
			in_col_q <= '0;
			in_row_q <= '0;
			ecol_q   <= '0;
			erow_q   <= '0;
		end else if (acc) begin
			if (tag0.emit && tag0.last) begin
				in_col_q <= '0;
				in_row_q <= '0;
				ecol_q   <= '0;
				erow_q   <= '0;
			end else begin
				if (tag0.emit) begin
					if (hrd_pkg::dim_t'(ecol_q) + hrd_pkg::dim_t'(1) >= cols_eff) begin
						ecol_q <= '0;
						erow_q <= erow_q + hrd_pkg::row_t'(1);
					end else begin
						ecol_q <= ecol_q + hrd_pkg::col_t'(1);
					end
				end
				if (hrd_pkg::dim_t'(in_col_q) + hrd_pkg::dim_t'(1) >= cols_eff) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + hrd_pkg::irow_t'(1);
				end else begin
					in_col_q <= in_col_q + hrd_pkg::col_t'(1);
				end
			end
		end
	end

	// line buffer: read on accept, write back when stage 1 advances
	assign wr_en    = adv && v_s1;
	assign line_old = fwd_s1 ? wr_last_q : line_rd_s1;
	assign wr_line  = '{up1: cur_s1, up2: line_old.up1};

	always_ff @(posedge clk) begin
		if (wr_en)
			row_mem[addr_s1] <= wr_line;
		if (acc)
			line_rd_s1 <= row_mem[in_col_q];
	end

	// keep the last written entry to forward a same-column read
	always_ff @(posedge clk) begin
		if (wr_en)
			wr_last_q <= wr_line;
		if (acc) begin
			fwd_s1  <= wr_en && (addr_s1 == in_col_q);
			addr_s1 <= in_col_q;
			cur_s1  <= item0;
			tag_s1  <= tag0;
		end
	end

	// stage 1: drop rows above the top edge, merge the two upper rows
	assign up1_m = tag_s1.rv1 ? line_old.up1 : hrd_pkg::EMPTY_SPAN;
	assign up2_m = tag_s1.rv2 ? line_old.up2 : hrd_pkg::EMPTY_SPAN;

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			pair_s2 <= hrd_pkg::span_merge(up1_m, up2_m);
			cur_s2  <= cur_s1;
			tag_s2  <= tag_s1;
		end
	end

	// stage 2: finish the column, merge the two older columns, shift the window
	assign vcol  = hrd_pkg::span_merge(pair_s2, cur_s2);
	assign horiz = hrd_pkg::span_merge(win_a_q,
		tag_s2.left ? win_b_q : hrd_pkg::EMPTY_SPAN);

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			win_b_q  <= win_a_q;
			win_a_q  <= vcol;
			vcol_s3  <= vcol;
			horiz_s3 <= horiz;
			tag_s3   <= tag_s2;
		end
	end

	// stage 3: add the current column unless it is past the right edge
	always_comb begin
		res3.span = hrd_pkg::span_merge(horiz_s3,
			tag_s3.incl_cur ? vcol_s3 : hrd_pkg::EMPTY_SPAN);
		res3.col  = tag_s3.col;
		res3.row  = tag_s3.row;
		res3.last = tag_s3.last;
	end

	assign push = adv && v_s3;

	// advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && tag_s2.emit;
		end
	end

	// output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || res_out.ready) begin
			out_v_q  <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || res_out.ready) begin
			if (skid_v_q)
				out_q <= skid_q;
			else if (push)
				out_q <= res3;
		end else if (push) begin
			skid_q <= res3;
		end
	end

	assign res_out.valid         = out_v_q;
	assign res_out.dilated_min   = out_q.span.mn;
	assign res_out.dilated_max   = out_q.span.mx;
	assign res_out.out_col       = out_q.col;
	assign res_out.out_row       = out_q.row;
	assign res_out.last_of_frame = out_q.last;

	// skid entry is only used behind an occupied output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry valid while output register empty");

	// a result arriving at a stalled output lands in the skid entry
	a_stall_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(push && out_v_q && !res_out.ready) |=> skid_v_q)
		else $error("result lost at stalled output");

	// stream positions stay inside the frame (the input row may reach rows+1)
	a_pos_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(hrd_pkg::dim_t'(in_col_q) < cols_eff) && (hrd_pkg::dim_t'(ecol_q) < cols_eff) &&
		(hrd_pkg::dim_t'(erow_q) < rows_eff) &&
		(int'(in_row_q) <= int'(rows_eff) + 1))
		else $error("stream position outside the frame");

	// the final result of a frame restarts the input position
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && tag0.emit && tag0.last) |=> (in_col_q == '0 && in_row_q == '0))
		else $error("frame did not restart after its last result");

endmodule
